>>> src/psio_pkg.sv
// psio_pkg: types, codes and constants for the joypad serial port controller
// used by psio_step, psio_state and pad_serial_port_controller; no dependencies
`default_nettype none

package psio_pkg;

    // tick scaling of the baud register
    localparam int unsigned TICKS_PER_BAUD_UNIT = 8;
    localparam int unsigned TICK_SHIFT          = $clog2(TICKS_PER_BAUD_UNIT);

    localparam int unsigned TIMER_W = 20;
    localparam int unsigned DELAY_W = 12;
    localparam int unsigned CFG_IDX_W = 1;

    // command codes
    localparam logic [1:0] CMD_READ  = 2'd0;
    localparam logic [1:0] CMD_WRITE = 2'd1;
    localparam logic [1:0] CMD_TICK  = 2'd2;

    // register offsets
    localparam logic [3:0] ADDR_DATA = 4'h0;
    localparam logic [3:0] ADDR_STAT = 4'h4;
    localparam logic [3:0] ADDR_MODE = 4'h8;
    localparam logic [3:0] ADDR_CTRL = 4'hA;
    localparam logic [3:0] ADDR_BAUD = 4'hE;

    // control bit positions
    localparam int unsigned CTRL_TXEN     = 0;
    localparam int unsigned CTRL_SEL      = 1;
    localparam int unsigned CTRL_RXEN     = 2;
    localparam int unsigned CTRL_ACK      = 4;
    localparam int unsigned CTRL_RST      = 6;
    localparam int unsigned CTRL_TXIE     = 10;
    localparam int unsigned CTRL_RXIE     = 11;
    localparam int unsigned CTRL_ACKIE    = 12;
    localparam int unsigned CTRL_PORT_SEL = 13;

    // stat bit positions
    localparam int unsigned STAT_TX_RDY  = 0;
    localparam int unsigned STAT_RX_NE   = 1;
    localparam int unsigned STAT_TX_DONE = 2;
    localparam int unsigned STAT_ACK     = 7;
    localparam int unsigned STAT_INTR    = 9;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_PAD  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_CARD = 1'd1;

    localparam logic [DELAY_W-1:0] ACK_DELAY_PAD_RST  = 12'd450;
    localparam logic [DELAY_W-1:0] ACK_DELAY_CARD_RST = 12'd170;

    localparam logic [7:0]  RX_EMPTY_BYTE = 8'hFF;
    localparam logic [31:0] RD_UNKNOWN    = 32'hFFFF_FFFF;

    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_XMIT = 2'd1,
        PH_WAIT = 2'd2
    } phase_t;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [3:0]  bus_addr;
        logic [31:0] write_data;
        logic [7:0]  device_byte;
        logic        device_ack;
        logic        device_is_card;
    } in_item_t;

    typedef struct packed {
        logic [31:0] read_data;
        logic        irq_line;
        logic        shift_start;
        logic [7:0]  shift_byte;
        logic        port_slot;
        logic        deselect_pulse;
        logic        busy_res;
    } out_item_t;

    typedef struct packed {
        logic [DELAY_W-1:0] ack_delay_pad;
        logic [DELAY_W-1:0] ack_delay_card;
    } cfg_t;

    typedef struct packed {
        phase_t             phase;
        logic [TIMER_W-1:0] event_timer;
        logic [15:0]        control;
        logic [15:0]        mode;
        logic [15:0]        baud;
        logic               ack_seen;
        logic               intr_flag;
        logic               irq_level;
        logic [7:0]         rx_byte;
        logic               rx_full;
        logic [7:0]         tx_hold;
        logic               tx_full;
        logic [7:0]         tx_shift;
    } state_t;

    localparam state_t STATE_RESET = '{
        phase:       PH_IDLE,
        event_timer: '0,
        control:     '0,
        mode:        '0,
        baud:        '0,
        ack_seen:    1'b0,
        intr_flag:   1'b0,
        irq_level:   1'b0,
        rx_byte:     '0,
        rx_full:     1'b0,
        tx_hold:     '0,
        tx_full:     1'b0,
        tx_shift:    '0
    };

    localparam cfg_t CFG_RESET = '{
        ack_delay_pad:  ACK_DELAY_PAD_RST,
        ack_delay_card: ACK_DELAY_CARD_RST
    };

endpackage

`default_nettype wire

>>> src/psio_step.sv
// psio_step: next-state and result logic for one bus access or tick
// depends on psio_pkg
`default_nettype none

module psio_step (
    input  psio_pkg::state_t   cur_state,
    input  psio_pkg::cfg_t     cfg,
    input  psio_pkg::in_item_t item,
    output psio_pkg::state_t   next_state,
    output psio_pkg::out_item_t result
);
    import psio_pkg::*;

    function automatic logic can_send(input state_t st);
        return st.tx_full && st.control[CTRL_SEL] && st.control[CTRL_TXEN];
    endfunction

    function automatic state_t begin_send(input state_t st);
        state_t s;
        s = st;
        s.control[CTRL_RXEN] = 1'b1;
        s.tx_shift    = s.tx_hold;
        s.tx_full     = 1'b0;
        s.phase       = PH_XMIT;
        s.event_timer = TIMER_W'({s.baud, TICK_SHIFT'(0)});
        return s;
    endfunction

    // completes the pending byte or ack wait
    function automatic state_t fire_event(input state_t st, input in_item_t it,
                                          input cfg_t cf, output logic started);
        state_t s;
        s = st;
        started = 1'b0;
        if (s.phase == PH_XMIT) begin
            s.control[CTRL_RXEN] = 1'b1;
            s.rx_byte = it.device_byte;
            s.rx_full = 1'b1;
            if (s.control[CTRL_RXIE]) begin
                s.intr_flag = 1'b1;
                s.irq_level = 1'b1;
            end
            if (!it.device_ack) begin
                s.phase = PH_IDLE;
            end else begin
                s.phase       = PH_WAIT;
                s.event_timer = it.device_is_card ? TIMER_W'(cf.ack_delay_card)
                                                  : TIMER_W'(cf.ack_delay_pad);
            end
        end else begin
            s.ack_seen = 1'b1;
            if (s.control[CTRL_ACKIE]) begin
                s.intr_flag = 1'b1;
                s.irq_level = 1'b1;
            end
            s.phase = PH_IDLE;
            if (can_send(s)) begin
                s = begin_send(s);
                started = 1'b1;
            end
        end
        return s;
    endfunction

    always_comb begin
        state_t      s;
        logic        st_start;
        logic        st_desel;
        logic        fired;
        logic [31:0] rd;
        logic [7:0]  v;

        s        = cur_state;
        st_start = 1'b0;
        st_desel = 1'b0;
        fired    = 1'b0;
        rd       = '0;
        v        = '0;

        unique case (item.cmd)
            CMD_READ: begin
                unique case (item.bus_addr)
                    ADDR_DATA: begin
                        if (s.phase != PH_IDLE) begin
                            s = fire_event(s, item, cfg, fired);
                            st_start = st_start | fired;
                        end
                        v = s.rx_full ? s.rx_byte : RX_EMPTY_BYTE;
                        s.rx_full = 1'b0;
                        rd = {4{v}};
                    end
                    ADDR_STAT: begin
                        if (s.phase != PH_IDLE) begin
                            s = fire_event(s, item, cfg, fired);
                            st_start = st_start | fired;
                        end
                        rd[STAT_TX_RDY]  = !s.tx_full;
                        rd[STAT_RX_NE]   = s.rx_full;
                        rd[STAT_TX_DONE] = !s.tx_full && (s.phase != PH_XMIT);
                        rd[STAT_ACK]     = s.ack_seen;
                        rd[STAT_INTR]    = s.intr_flag;
                        s.ack_seen = 1'b0;
                    end
                    ADDR_MODE: rd = 32'(s.mode);
                    ADDR_CTRL: rd = 32'(s.control);
                    ADDR_BAUD: rd = 32'(s.baud);
                    default:   rd = RD_UNKNOWN;
                endcase
            end
            CMD_WRITE: begin
                unique case (item.bus_addr)
                    ADDR_DATA: begin
                        s.tx_hold = item.write_data[7:0];
                        s.tx_full = 1'b1;
                        if (s.control[CTRL_TXIE]) begin
                            s.intr_flag = 1'b1;
                            s.irq_level = 1'b1;
                        end
                        if (s.phase == PH_IDLE && can_send(s)) begin
                            s = begin_send(s);
                            st_start = 1'b1;
                        end
                    end
                    ADDR_CTRL: begin
                        s.control = item.write_data[15:0];
                        if (s.control[CTRL_RST]) begin
                            s.phase     = PH_IDLE;
                            s.control   = '0;
                            s.mode      = '0;
                            s.ack_seen  = 1'b0;
                            s.intr_flag = 1'b0;
                            s.rx_byte   = '0;
                            s.rx_full   = 1'b0;
                            s.tx_hold   = '0;
                            s.tx_full   = 1'b0;
                            st_desel    = 1'b1;
                        end
                        if (s.control[CTRL_ACK]) begin
                            s.intr_flag = 1'b0;
                            s.irq_level = 1'b0;
                        end
                        if (!s.control[CTRL_SEL]) begin
                            st_desel = 1'b1;
                        end
                        if (!s.control[CTRL_SEL] || !s.control[CTRL_TXEN]) begin
                            s.phase = PH_IDLE;
                        end else if (s.phase == PH_IDLE && can_send(s)) begin
                            s = begin_send(s);
                            st_start = 1'b1;
                        end
                    end
                    ADDR_MODE: s.mode = item.write_data[15:0];
                    ADDR_BAUD: s.baud = item.write_data[15:0];
                    default: ;
                endcase
            end
            CMD_TICK: begin
                if (s.phase != PH_IDLE) begin
                    if (s.event_timer <= TIMER_W'(1)) begin
                        s = fire_event(s, item, cfg, fired);
                        st_start = st_start | fired;
                    end else begin
                        s.event_timer = s.event_timer - TIMER_W'(1);
                    end
                end
            end
            default: ;
        endcase

        next_state            = s;
        result.read_data      = rd;
        result.irq_line       = s.irq_level;
        result.shift_start    = st_start;
        result.shift_byte     = s.tx_shift;
        result.port_slot      = s.control[CTRL_PORT_SEL];
        result.deselect_pulse = st_desel;
        result.busy_res       = (s.phase != PH_IDLE);
    end

endmodule

`default_nettype wire

>>> src/psio_state.sv
// psio_state: port state registers and the two ack delay registers
// depends on psio_pkg
`default_nettype none

module psio_state (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                upd_en,
    input  psio_pkg::state_t                    state_next,
    input  logic                                cfg_wr_en,
    input  logic [psio_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [psio_pkg::DELAY_W-1:0]        cfg_wr_data,
    output psio_pkg::state_t                    state_reg,
    output psio_pkg::cfg_t                      cfg_reg
);
    import psio_pkg::*;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= STATE_RESET;
        end else if (upd_en) begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= CFG_RESET;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_IDX_PAD:  cfg_reg.ack_delay_pad  <= cfg_wr_data;
                CFG_IDX_CARD: cfg_reg.ack_delay_card <= cfg_wr_data;
                default: ;
            endcase
        end
    end

endmodule

`default_nettype wire

>>> src/pad_serial_port_controller.sv
// pad_serial_port_controller: top level of the joypad serial port
// depends on psio_pkg, psio_step and psio_state
`default_nettype none

// channel   direction  handshake            payload
// s_        in         s_valid / s_ready    psio_pkg::in_item_t  (bus access or tick)
// m_        out        m_valid / m_ready    psio_pkg::out_item_t (one result per item)
// cfg_      in         cfg_wr_en            cfg_index, cfg_wr_data (ack delays)
//
// one item per cycle sustained while m_ready holds; path: input register, then the
// step logic into the result register, where the port state is updated too
// the step logic is a single pass of register updates and compares per item
// reset is synchronous on aresetn low, no clearing pass
// a stalled result holds in the result register; the input register keeps
// taking one more transfer, then s_ready drops until m_ready returns

module pad_serial_port_controller (
    input  logic                            aclk,
    input  logic                            aresetn,

    input  logic                            s_valid,
    output logic                            s_ready,
    input  psio_pkg::in_item_t              s_data,

    output logic                            m_valid,
    input  logic                            m_ready,
    output psio_pkg::out_item_t             m_data,

    input  logic                            cfg_wr_en,
    input  logic [psio_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [psio_pkg::DELAY_W-1:0]    cfg_wr_data
);
    import psio_pkg::*;

    // input stage
    in_item_t  in_item_reg;
    logic      in_valid_reg;

    // result stage
    out_item_t out_item_reg;
    logic      out_valid_reg;

    // step logic wiring
    state_t    state_reg;
    state_t    state_next;
    cfg_t      cfg_reg;
    out_item_t step_result;

    logic      advance;

    // the held item moves on when the result register is free or being emptied
    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    // payload only, no reset needed
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_item_reg <= s_data;
        end
    end

    psio_step u_step (
        .cur_state  (state_reg),
        .cfg        (cfg_reg),
        .item       (in_item_reg),
        .next_state (state_next),
        .result     (step_result)
    );

    // port state commits when the item leaves the input stage
    psio_state u_state (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .upd_en      (advance),
        .state_next  (state_next),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wr_data (cfg_wr_data),
        .state_reg   (state_reg),
        .cfg_reg     (cfg_reg)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_item_reg <= step_result;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_item_reg;

    // a transfer or ack wait only runs with select and tx enable both set
    a_busy_needs_sel: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg.phase != PH_IDLE) |->
            (state_reg.control[CTRL_SEL] && state_reg.control[CTRL_TXEN]))
        else $error("port busy without select and tx enable");

    // every item leaving the input stage shows up as a result
    a_advance_gives_result: assert property (@(posedge aclk) disable iff (!aresetn)
        advance |=> m_valid)
        else $error("item lost between input and result stage");

    // a started byte always leaves the port busy
    a_start_is_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.shift_start) |-> m_data.busy_res)
        else $error("shift start reported while port idle");

endmodule

`default_nettype wire
